// ===== rtl/pcll_pkg.sv =====
`default_nettype none

package pcll_pkg;

	// default sizes
	localparam int NUM_CLASSES_DEF   = 12;
	localparam int MAX_PER_CLASS_DEF = 16;
	localparam int SQUARE_BITS_DEF   = 6;

	// fixed port widths
	localparam int CMD_W   = 2;
	localparam int CLASS_W = 4;
	localparam int SQ_W    = 6;
	localparam int STS_W   = 2;
	localparam int COUNT_W = 5;

	// command codes
	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

	// status codes
	localparam logic [STS_W-1:0] STS_DONE    = 2'd0;
	localparam logic [STS_W-1:0] STS_MISSING = 2'd1;
	localparam logic [STS_W-1:0] STS_FULL    = 2'd2;
	localparam logic [STS_W-1:0] STS_REJECT  = 2'd3;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_MOVE,
		ST_RESP
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/per_class_location_list.sv =====
// Sequence: an accepted command is executed in EXEC; add, rejects and empty lists then go
// straight to RESP, while update and remove scan the class's entries (at most MAX_PER_CLASS,
// one entry per cycle) and a remove hit passes through MOVE before RESP.
// Throughput: one transaction at a time; in_stall is held until the result is loaded out.
// Reset: arst_n clears the sequencer, the output valid and all per-class counts;
// the location memory is not cleared, entries are read only below a class's count.
`default_nettype none

module per_class_location_list #(
	parameter int NUM_CLASSES   = pcll_pkg::NUM_CLASSES_DEF,
	parameter int MAX_PER_CLASS = pcll_pkg::MAX_PER_CLASS_DEF,
	parameter int SQUARE_BITS   = pcll_pkg::SQUARE_BITS_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire  [pcll_pkg::CMD_W-1:0]     command,
	input  wire  [pcll_pkg::CLASS_W-1:0]   piece_class,
	input  wire  [pcll_pkg::SQ_W-1:0]      square,
	input  wire  [pcll_pkg::SQ_W-1:0]      new_square,
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic [pcll_pkg::STS_W-1:0]     status,
	output logic [pcll_pkg::COUNT_W-1:0]   class_count
);

	localparam int IDX_W    = (MAX_PER_CLASS > 1) ? $clog2(MAX_PER_CLASS) : 1;
	localparam int CNT_W    = $clog2(MAX_PER_CLASS + 1);
	localparam int CLS_W    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int ADDR_W   = CLS_W + IDX_W;
	localparam int MEM_DEPTH = NUM_CLASSES << IDX_W;

	// transaction registers
	pcll_pkg::state_t                  state_q, state_d;
	logic [pcll_pkg::CMD_W-1:0]        cmd_q;
	logic [pcll_pkg::CLASS_W-1:0]      cls_q;
	logic [SQUARE_BITS-1:0]            sq_q;
	logic [SQUARE_BITS-1:0]            nsq_q;
	logic [IDX_W-1:0]                  idx_q, idx_d;
	logic [pcll_pkg::STS_W-1:0]        sts_q, sts_d;
	logic                              out_valid_q;
	logic [pcll_pkg::STS_W-1:0]        status_q;
	logic [pcll_pkg::COUNT_W-1:0]      class_count_q;

	// per-class counts
	logic [CNT_W-1:0]                  cnt_q [NUM_CLASSES];
	logic                              cnt_we;
	logic [CNT_W-1:0]                  cnt_wdata;

	// location memory
	logic [SQUARE_BITS-1:0]            loc_mem [0:MEM_DEPTH-1];
	logic [SQUARE_BITS-1:0]            rd_data_q;
	logic [ADDR_W-1:0]                 rd_addr;
	logic                              mem_we;
	logic [ADDR_W-1:0]                 wr_addr;
	logic [SQUARE_BITS-1:0]            wr_data;

	logic                              in_take;
	logic                              cls_ok;
	logic [CLS_W-1:0]                  cls_idx;
	logic [CNT_W-1:0]                  cur_cnt;
	logic [CNT_W-1:0]                  last_cnt;
	logic                              at_last;
	logic                              out_load;

	assign in_stall  = (state_q != pcll_pkg::ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign class_count = class_count_q;

	// class decode and count lookup
	assign cls_ok   = ({1'b0, cls_q} < (pcll_pkg::CLASS_W + 1)'(NUM_CLASSES));
	assign cls_idx  = cls_q[CLS_W-1:0];
	assign cur_cnt  = cls_ok ? cnt_q[cls_idx] : '0;
	assign last_cnt = cur_cnt - CNT_W'(1);
	assign at_last  = (CNT_W'(idx_q) == last_cnt);

	// sequencer next state and datapath controls
	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		sts_d     = sts_q;
		cnt_we    = 1'b0;
		cnt_wdata = cur_cnt;
		mem_we    = 1'b0;
		wr_addr   = {cls_idx, idx_q};
		wr_data   = nsq_q;
		rd_addr   = {cls_idx, idx_q};
		out_load  = 1'b0;
		unique case (state_q)
			pcll_pkg::ST_IDLE: begin
				if (in_take) begin
					state_d = pcll_pkg::ST_EXEC;
				end
			end
			pcll_pkg::ST_EXEC: begin
				idx_d   = '0;
				rd_addr = {cls_idx, {IDX_W{1'b0}}};
				state_d = pcll_pkg::ST_RESP;
				if (!cls_ok) begin
					sts_d = pcll_pkg::STS_REJECT;
				end else begin
					unique case (cmd_q)
						pcll_pkg::CMD_ADD: begin
							if (cur_cnt >= CNT_W'(MAX_PER_CLASS)) begin
								sts_d = pcll_pkg::STS_FULL;
							end else begin
								mem_we    = 1'b1;
								wr_addr   = {cls_idx, cur_cnt[IDX_W-1:0]};
								wr_data   = sq_q;
								cnt_we    = 1'b1;
								cnt_wdata = cur_cnt + CNT_W'(1);
								sts_d     = pcll_pkg::STS_DONE;
							end
						end
						pcll_pkg::CMD_UPDATE, pcll_pkg::CMD_REMOVE: begin
							if (cur_cnt == '0) begin
								sts_d = pcll_pkg::STS_MISSING;
							end else begin
								state_d = pcll_pkg::ST_SCAN;
							end
						end
						default: begin
							sts_d = pcll_pkg::STS_REJECT;
						end
					endcase
				end
			end
			pcll_pkg::ST_SCAN: begin
				// rd_data_q holds entry idx_q
				if (rd_data_q == sq_q) begin
					if (cmd_q == pcll_pkg::CMD_UPDATE) begin
						mem_we  = 1'b1;
						wr_data = nsq_q;
						sts_d   = pcll_pkg::STS_DONE;
						state_d = pcll_pkg::ST_RESP;
					end else begin
						rd_addr = {cls_idx, last_cnt[IDX_W-1:0]};
						state_d = pcll_pkg::ST_MOVE;
					end
				end else if (at_last) begin
					sts_d   = pcll_pkg::STS_MISSING;
					state_d = pcll_pkg::ST_RESP;
				end else begin
					idx_d   = idx_q + IDX_W'(1);
					rd_addr = {cls_idx, idx_d};
				end
			end
			pcll_pkg::ST_MOVE: begin
				// last entry fills the hole
				mem_we    = 1'b1;
				wr_data   = rd_data_q;
				cnt_we    = 1'b1;
				cnt_wdata = last_cnt;
				sts_d     = pcll_pkg::STS_DONE;
				state_d   = pcll_pkg::ST_RESP;
			end
			pcll_pkg::ST_RESP: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = pcll_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pcll_pkg::ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcll_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// transaction capture and scan registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_q <= command;
			cls_q <= piece_class;
			sq_q  <= SQUARE_BITS'(square);
			nsq_q <= SQUARE_BITS'(new_square);
		end
		idx_q <= idx_d;
		sts_q <= sts_d;
	end

	// per-class counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (cnt_we) begin
			cnt_q[cls_idx] <= cnt_wdata;
		end
	end

	// location memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			loc_mem[wr_addr] <= wr_data;
		end
		rd_data_q <= loc_mem[rd_addr];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q      <= sts_q;
			class_count_q <= pcll_pkg::COUNT_W'(cur_cnt);
		end
	end

`ifndef SYNTHESIS
	// a new result only comes out of the response state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == pcll_pkg::ST_RESP))
		else $error("result without response state");

	// the addressed count never passes the list size
	assert property (@(posedge clk) disable iff (!arst_n)
		cls_ok |-> (cur_cnt <= CNT_W'(MAX_PER_CLASS)))
		else $error("class count over list size");

	// the scan stays below the class count
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pcll_pkg::ST_SCAN) |-> (CNT_W'(idx_q) < cur_cnt))
		else $error("scan index beyond count");

	// a remove only moves an entry of a non-empty list
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pcll_pkg::ST_MOVE) |-> (cur_cnt != '0))
		else $error("remove on empty list");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

	import pcll_pkg::*;

	localparam int NUM_CLASSES   = NUM_CLASSES_DEF;
	localparam int MAX_PER_CLASS = MAX_PER_CLASS_DEF;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int CLASS_MAX_CODE = (1 << CLASS_W) - 1;
	localparam int SQ_MAX_CODE    = (1 << SQ_W) - 1;

	typedef struct packed {
		logic [STS_W-1:0]   status;
		logic [COUNT_W-1:0] count;
	} list_result_t;

	logic                 clk;
	logic                 arst_n      = 1'b0;
	logic                 in_valid    = 1'b0;
	logic                 in_stall;
	logic [CMD_W-1:0]     command     = '0;
	logic [CLASS_W-1:0]   piece_class = '0;
	logic [SQ_W-1:0]      square      = '0;
	logic [SQ_W-1:0]      new_square  = '0;
	logic                 out_valid;
	logic                 out_stall   = 1'b0;
	logic [STS_W-1:0]     status;
	logic [COUNT_W-1:0]   class_count;

	// shadow copy of the per-class lists
	logic [COUNT_W-1:0] class_len [NUM_CLASSES];
	logic [SQ_W-1:0]    class_locs [NUM_CLASSES][MAX_PER_CLASS];

	list_result_t pending_results[$];
	list_result_t oldest_result;
	int           mismatches      = 0;
	int           sender_idle_pct = 0;
	int           recv_stall_pct  = 0;

	per_class_location_list dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.piece_class (piece_class),
		.square      (square),
		.new_square  (new_square),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.class_count (class_count)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog
	initial begin
		#5ms;
		$display("[per_class_location_list] ERROR");
		$finish;
	end

	// apply one command to the shadow lists and return the expected result
	function automatic list_result_t apply_move(logic [CMD_W-1:0] cmd, int cls,
			logic [SQ_W-1:0] sq, logic [SQ_W-1:0] nsq);
		list_result_t r;
		int n;
		int hit;
		r.status = STS_DONE;
		r.count  = '0;
		hit = -1;
		if (cls >= NUM_CLASSES) begin
			r.status = STS_REJECT;
			return r;
		end
		n = class_len[cls];
		// lowest-indexed match for update and remove
		for (int i = 0; i < n; i++) begin
			if (hit < 0 && class_locs[cls][i] == sq)
				hit = i;
		end
		case (cmd)
			CMD_ADD: begin
				if (n >= MAX_PER_CLASS) begin
					r.status = STS_FULL;
				end else begin
					class_locs[cls][n] = sq;
					class_len[cls] = COUNT_W'(n + 1);
				end
			end
			CMD_UPDATE: begin
				if (hit < 0)
					r.status = STS_MISSING;
				else
					class_locs[cls][hit] = nsq;
			end
			CMD_REMOVE: begin
				if (hit < 0) begin
					r.status = STS_MISSING;
				end else begin
					class_locs[cls][hit] = class_locs[cls][n-1];
					class_len[cls] = COUNT_W'(n - 1);
				end
			end
			default: r.status = STS_REJECT;
		endcase
		r.count = class_len[cls];
		return r;
	endfunction

	// send one transaction, with optional idle cycles ahead of it
	task automatic send_move(logic [CMD_W-1:0] cmd, int cls, int sq, int nsq);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		command     <= cmd;
		piece_class <= CLASS_W'(cls);
		square      <= SQ_W'(sq);
		new_square  <= SQ_W'(nsq);
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.push_back(apply_move(cmd, cls, SQ_W'(sq), SQ_W'(nsq)));
	endtask

	// hold off the sender until every result is back
	task automatic drain_moves();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic note_mismatch(string what, int exp_val, int got_val);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t mismatch %s: expected %0d, got %0d", $realtime, what, exp_val,
				got_val);
	endtask

	// receiver back-pressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				note_mismatch("unexpected transaction, status", -1, status);
			end else begin
				oldest_result = pending_results.pop_front();
				if (status !== oldest_result.status)
					note_mismatch("status", oldest_result.status, status);
				if (class_count !== oldest_result.count)
					note_mismatch("class_count", oldest_result.count, class_count);
			end
		end
	end

	// add, duplicate handling, misses, unknown command, class out of range
	task automatic test_basic_moves();
		send_move(CMD_ADD, 0, 0, 0);
		send_move(CMD_ADD, 0, SQ_MAX_CODE, 0);
		send_move(CMD_UPDATE, 0, SQ_MAX_CODE, 0);
		send_move(CMD_UPDATE, 0, 0, 42);
		send_move(CMD_REMOVE, 0, 0, SQ_MAX_CODE);
		send_move(CMD_REMOVE, 0, 5, 0);
		send_move(CMD_UPDATE, 3, 21, 10);
		send_move(CMD_UNUSED, 0, 42, 21);
		send_move(CMD_ADD, CLASS_MAX_CODE, 9, 9);
	endtask

	// fill one list, add past full, then remove its first entry
	task automatic test_full_list();
		for (int i = 0; i < MAX_PER_CLASS; i++)
			send_move(CMD_ADD, NUM_CLASSES - 5, i * 4 + 3, 0);
		send_move(CMD_ADD, NUM_CLASSES - 5, 60, 0);
		send_move(CMD_REMOVE, NUM_CLASSES - 5, 3, 0);
	endtask

	function automatic int pick_square();
		if ($urandom_range(99) < 30)
			return $urandom_range(7);
		return $urandom_range(SQ_MAX_CODE);
	endfunction

	// random traffic, mostly valid commands aimed at squares that exist
	task automatic test_random_moves(int n_items, int add_pct, int upd_pct, int rem_pct,
			int cls_hi);
		int roll;
		int cls;
		int sq;
		int nsq;
		logic [CMD_W-1:0] cmd;
		for (int k = 0; k < n_items; k++) begin
			roll = $urandom_range(99);
			cls  = $urandom_range(cls_hi);
			if (roll < add_pct) begin
				cmd = CMD_ADD;
			end else if (roll < add_pct + upd_pct) begin
				cmd = CMD_UPDATE;
			end else if (roll < add_pct + upd_pct + rem_pct) begin
				cmd = CMD_REMOVE;
			end else if ($urandom_range(1) == 1) begin
				cmd = CMD_UNUSED;
				cls = $urandom_range(NUM_CLASSES - 1);
			end else begin
				cmd = CMD_W'($urandom_range(3));
				cls = $urandom_range(CLASS_MAX_CODE, NUM_CLASSES);
			end
			sq  = pick_square();
			nsq = pick_square();
			if ((cmd == CMD_UPDATE || cmd == CMD_REMOVE) && cls < NUM_CLASSES
					&& class_len[cls] != 0 && $urandom_range(99) < 80)
				sq = class_locs[cls][$urandom_range(class_len[cls] - 1)];
			send_move(cmd, cls, sq, nsq);
		end
	endtask

	// main sequence
	initial begin
		for (int c = 0; c < NUM_CLASSES; c++)
			class_len[c] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_moves();
		test_full_list();
		drain_moves();

		// no idling, adds crowded onto a few classes so lists fill up
		sender_idle_pct = 0;
		recv_stall_pct  = 0;
		test_random_moves(170, 55, 15, 22, 2);
		drain_moves();

		sender_idle_pct = 56;
		recv_stall_pct  = 0;
		test_random_moves(170, 35, 25, 33, NUM_CLASSES - 1);
		drain_moves();

		sender_idle_pct = 0;
		recv_stall_pct  = 56;
		test_random_moves(170, 25, 25, 43, NUM_CLASSES - 1);
		drain_moves();

		sender_idle_pct = 8;
		recv_stall_pct  = 8;
		test_random_moves(170, 40, 25, 28, NUM_CLASSES - 1);
		drain_moves();

		recv_stall_pct = 0;
		repeat (3 * MAX_PER_CLASS) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("[per_class_location_list] OK");
		else
			$display("[per_class_location_list] ERROR");
		$finish;
	end

endmodule
